### hdl/vtpi_pkg.sv
// Shared constants, tables and the stage type for the voltage to PWM interpolator.
`timescale 1ns / 1ps
`default_nettype none
package vtpi_pkg;

	localparam int TABLE_POINTS = 19;
	localparam int SEGS         = TABLE_POINTS - 1;
	localparam int IW           = $clog2(TABLE_POINTS);
	localparam int SW           = (SEGS > 1) ? $clog2(SEGS) : 1;

	localparam int VW    = 16;  // voltage width
	localparam int PW    = 12;  // pwm width
	localparam int DVW   = 8;   // segment voltage span width
	localparam int DPW   = 9;   // segment pwm rise width
	localparam int NW    = DVW + DPW;
	localparam int RW    = 16;  // reciprocal width
	localparam int SHIFT = 20;  // reciprocal scale, 2**SHIFT / span
	localparam int QW    = DPW + 1;
	localparam int MW    = QW + DVW;
	localparam int CW    = ((NW > MW) ? NW : MW) + 2;

	localparam logic [PW-1:0] PWM_TBL [TABLE_POINTS] = '{
		12'd0, 12'd60, 12'd120, 12'd180, 12'd240, 12'd300, 12'd360, 12'd420,
		12'd480, 12'd540, 12'd600, 12'd660, 12'd720, 12'd1080, 12'd1440,
		12'd1800, 12'd2160, 12'd2520, 12'd2880
	};

	localparam logic [VW-1:0] VOLT_TBL [TABLE_POINTS] = '{
		16'd1586, 16'd1817, 16'd1980, 16'd2126, 16'd2242, 16'd2321, 16'd2377,
		16'd2422, 16'd2456, 16'd2489, 16'd2521, 16'd2546, 16'd2573, 16'd2694,
		16'd2782, 16'd2837, 16'd2895, 16'd2955, 16'd3016
	};

	// Near 2**SHIFT / span for each segment; the last stage corrects by one either way.
	localparam logic [RW-1:0] RECIP_TBL [SEGS] = '{
		16'd4539, 16'd6432, 16'd7182, 16'd9039, 16'd13273, 16'd18724,
		16'd23301, 16'd30840, 16'd31775, 16'd32768, 16'd41943, 16'd38836,
		16'd8665, 16'd11915, 16'd19065, 16'd18078, 16'd17476, 16'd17189
	};

	function automatic logic [DVW-1:0] seg_dv(input logic [SW-1:0] seg);
		logic [VW-1:0] diff;
		diff = VOLT_TBL[seg + 1'b1] - VOLT_TBL[seg];
		return diff[DVW-1:0];
	endfunction

	function automatic logic [DPW-1:0] seg_dp(input logic [SW-1:0] seg);
		logic [PW-1:0] diff;
		diff = (PWM_TBL[seg + 1'b1] > PWM_TBL[seg]) ?
			PWM_TBL[seg + 1'b1] - PWM_TBL[seg] : '0;
		return diff[DPW-1:0];
	endfunction

	typedef struct packed {
		logic [DVW-1:0] x;
		logic [PW-1:0]  p0;
		logic [DPW-1:0] dp;
		logic [DVW-1:0] dv;
		logic [RW-1:0]  recip;
	} seg_t;

endpackage
`default_nettype wire

### hdl/vtpi_locate.sv
// Segment search: compare against table points, encode the segment, fetch its constants.
`timescale 1ns / 1ps
`default_nettype none
module vtpi_locate
	import vtpi_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [VW-1:0] voltage,
	output logic               out_valid,
	input  wire logic          out_ready,
	output seg_t               out_data
);

	logic            valid_s1, valid_s2, valid_s3;
	logic            adv1, adv2, adv3;
	logic [SEGS-1:0] therm_s1;
	logic            below_s1;
	logic [VW-1:0]   volt_s1, volt_s2;
	logic [IW-1:0]   idx_s2;
	logic            zero_s2;
	seg_t            data_s3;

	logic [SEGS-1:0] therm;
	logic [IW-1:0]   idx;
	logic [SW-1:0]   seg;
	logic [VW-1:0]   xfull;
	seg_t            data;

	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		for (int k = 0; k < SEGS; k++) begin
			therm[k] = voltage >= VOLT_TBL[k + 1];
		end
	end

	// Rising table gives a thermometer code; pick out its top edge.
	always_comb begin
		idx = '0;
		for (int k = 0; k < SEGS; k++) begin
			if (therm_s1[k] && (k == SEGS - 1 || !therm_s1[(k + 1) % SEGS])) begin
				idx = idx | IW'(k + 1);
			end
		end
	end

	always_comb begin
		seg = (idx_s2 == IW'(TABLE_POINTS - 1)) ? SW'(SEGS - 1) : idx_s2[SW-1:0];
		xfull      = volt_s2 - VOLT_TBL[idx_s2];
		data.x     = zero_s2 ? '0 : xfull[DVW-1:0];
		data.p0    = PWM_TBL[idx_s2];
		data.dp    = seg_dp(seg);
		data.dv    = seg_dv(seg);
		data.recip = RECIP_TBL[seg];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			therm_s1 <= therm;
			below_s1 <= voltage < VOLT_TBL[0];
			volt_s1  <= voltage;
		end
		if (adv2) begin
			idx_s2  <= idx;
			// Clamp both ends: no offset into the segment.
			zero_s2 <= below_s1 || therm_s1[SEGS-1];
			volt_s2 <= volt_s1;
		end
		if (adv3) begin
			data_s3 <= data;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule
`default_nettype wire

### hdl/vtpi_scale.sv
// Interpolation arithmetic: offset times rise, reciprocal divide, one-step correction.
`timescale 1ns / 1ps
`default_nettype none
module vtpi_scale
	import vtpi_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire seg_t          in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [PW-1:0]      pwm
);

	logic           valid_s4, valid_s5, valid_s6;
	logic           adv4, adv5, adv6;
	logic [NW-1:0]  n_s4, n_s5;
	logic [PW-1:0]  p0_s4, p0_s5;
	logic [DVW-1:0] dv_s4, dv_s5;
	logic [RW-1:0]  recip_s4;
	logic [QW-1:0]  q0_s5;
	logic [PW-1:0]  pwm_s6;

	logic [NW+RW-1:0]     prod;
	logic [MW-1:0]        chk;
	logic signed [CW-1:0] rem;
	logic [QW-1:0]        q;
	logic [PW:0]          sum;

	assign adv6     = !valid_s6 || out_ready;
	assign adv5     = !valid_s5 || adv6;
	assign adv4     = !valid_s4 || adv5;
	assign in_ready = adv4;

	assign prod = (NW+RW)'(n_s4) * (NW+RW)'(recip_s4);

	// Estimate is off by at most one; the remainder's sign and its size against the span tell which way.
	always_comb begin
		chk = MW'(q0_s5) * MW'(dv_s5);
		rem = $signed({{(CW-NW){1'b0}}, n_s5}) - $signed({{(CW-MW){1'b0}}, chk});
		if (rem < 0) begin
			q = q0_s5 - 1'b1;
		end else if (rem >= $signed({{(CW-DVW){1'b0}}, dv_s5})) begin
			q = q0_s5 + 1'b1;
		end else begin
			q = q0_s5;
		end
		sum = {1'b0, p0_s5} + (PW+1)'(q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv4) valid_s4 <= in_valid;
			if (adv5) valid_s5 <= valid_s4;
			if (adv6) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			n_s4     <= NW'(in_data.x) * NW'(in_data.dp);
			p0_s4    <= in_data.p0;
			dv_s4    <= in_data.dv;
			recip_s4 <= in_data.recip;
		end
		if (adv5) begin
			q0_s5 <= prod[SHIFT +: QW];
			n_s5  <= n_s4;
			p0_s5 <= p0_s4;
			dv_s5 <= dv_s4;
		end
		if (adv6) begin
			pwm_s6 <= sum[PW-1:0];
		end
	end

	assign out_valid = valid_s6;
	assign pwm       = pwm_s6;

endmodule
`default_nettype wire

### hdl/voltage_to_pwm_interpolator_core.sv
// Top level of the voltage to PWM interpolator.
`timescale 1ns / 1ps
`default_nettype none
// Turns a requested voltage (10 mV units) into a PWM compare value by piecewise linear
// interpolation over a 19-point constant table, clamped to the first and last pwm values
// outside the table range, with the per-segment division truncating. The block is a
// six-stage pipeline: it takes one voltage every cycle when the output side does not
// stall, and its register stages are three for compare, segment encode and table fetch,
// and three for the offset multiply, the reciprocal multiply and the remainder correction.
// Each stage holds its transaction while the stage after it is full and cannot advance, so
// bubbles close up under back-pressure.
module voltage_to_pwm_interpolator_core
	import vtpi_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [VW-1:0] voltage,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [PW-1:0]      pwm
);

	logic seg_valid;
	logic seg_ready;
	seg_t seg_data;

	vtpi_locate u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.voltage   (voltage),
		.out_valid (seg_valid),
		.out_ready (seg_ready),
		.out_data  (seg_data)
	);

	vtpi_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg_valid),
		.in_ready  (seg_ready),
		.in_data   (seg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pwm       (pwm)
	);

	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pwm <= PWM_TBL[TABLE_POINTS-1])
		else $error("pwm above table maximum");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("pipeline blocked while output drains");

	a_seg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid && $stable(seg_data))
		else $error("segment transaction lost under stall");

endmodule
`default_nettype wire

### dv/voltage_to_pwm_interpolator_core_tb.sv
// Testbench for the voltage to PWM interpolator core: directed and random setpoints, scoreboard.
`timescale 1ns / 1ps
module voltage_to_pwm_interpolator_core_tb;
	import vtpi_pkg::VW;
	import vtpi_pkg::PW;

	localparam int N_POINTS = 19;
	localparam int RANDOM_ITEMS = 800;

	localparam int PWM_POINTS [N_POINTS] = '{
		0, 60, 120, 180, 240, 300, 360, 420, 480, 540,
		600, 660, 720, 1080, 1440, 1800, 2160, 2520, 2880
	};
	localparam int VOLT_POINTS [N_POINTS] = '{
		1586, 1817, 1980, 2126, 2242, 2321, 2377, 2422, 2456, 2489,
		2521, 2546, 2573, 2694, 2782, 2837, 2895, 2955, 3016
	};

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [VW-1:0] voltage = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [PW-1:0] pwm;

	logic [VW-1:0] pending_volts [$];
	logic [PW-1:0] expected_pwm [$];
	logic [PW-1:0] want_pwm;
	logic          in_taken = 1'b0;
	int            send_gap = 0;
	int            send_quiet = 0;
	int            stall_left = 0;
	int            recv_quiet = 0;
	int            mismatch_count = 0;

	voltage_to_pwm_interpolator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.voltage   (voltage),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pwm       (pwm)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Piecewise linear lookup, clamped at both ends, truncating divide.
	function automatic logic [PW-1:0] volt_to_pwm(input logic [VW-1:0] v);
		int vi;
		int dp;
		int dv;
		int res;
		vi = int'(v);
		res = PWM_POINTS[N_POINTS-1];
		if (vi <= VOLT_POINTS[0]) begin
			res = PWM_POINTS[0];
		end else if (vi < VOLT_POINTS[N_POINTS-1]) begin
			for (int k = 0; k < N_POINTS - 1; k++) begin
				if (vi >= VOLT_POINTS[k] && vi < VOLT_POINTS[k+1]) begin
					dp = (PWM_POINTS[k+1] > PWM_POINTS[k]) ? PWM_POINTS[k+1] - PWM_POINTS[k] : 0;
					dv = VOLT_POINTS[k+1] - VOLT_POINTS[k];
					res = (dv == 0) ? PWM_POINTS[k] : PWM_POINTS[k] + ((vi - VOLT_POINTS[k]) * dp) / dv;
				end
			end
		end
		return res[PW-1:0];
	endfunction

	// Mostly short gaps, a few long ones, and now and then a run with none.
	function automatic int idle_len(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: MISMATCH %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Driver: hold the transaction until accepted, then advance.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_volts.size() > 0) begin
				voltage  <= pending_volts.pop_front();
				in_valid <= 1'b1;
				send_gap <= idle_len(send_quiet);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready  <= 1'b1;
			stall_left <= idle_len(recv_quiet);
		end
	end

	// Monitor: predict on input transactions, compare on output transactions.
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_pwm.push_back(volt_to_pwm(voltage));
		if (arst_n && out_valid && out_ready) begin
			if (expected_pwm.size() == 0) begin
				report_mismatch($sformatf("pwm %0d with no transaction pending", pwm));
			end else begin
				want_pwm = expected_pwm.pop_front();
				if (pwm !== want_pwm)
					report_mismatch($sformatf("pwm %0d, expected %0d", pwm, want_pwm));
			end
		end
	end

	initial begin
		int r;
		int p;
		// Extremes, table edges, and every table point.
		pending_volts.push_back(16'd0);
		pending_volts.push_back(16'hFFFF);
		pending_volts.push_back(16'd1585);
		pending_volts.push_back(16'd1587);
		pending_volts.push_back(16'd3015);
		pending_volts.push_back(16'd3017);
		for (int k = 0; k < N_POINTS; k++)
			pending_volts.push_back(VW'(VOLT_POINTS[k]));
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				pending_volts.push_back(VW'($urandom_range(1500, 3100)));
			end else if (r < 85) begin
				p = VOLT_POINTS[$urandom_range(0, N_POINTS - 1)] + $urandom_range(0, 4) - 2;
				pending_volts.push_back(VW'(p));
			end else begin
				pending_volts.push_back(VW'($urandom_range(0, 65535)));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_volts.size() > 0 || in_valid)
			@(posedge clk);
		while (expected_pwm.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
